@@ design/kpsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the keyed Polybius square cipher.
// Used by the front end, the item queue, the back end and the top level.
package kpsc_pkg;

   localparam int SQUARE_SIDE  = 6;
   localparam int SYMBOL_COUNT = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_COUNT = 26;
   localparam int SYM_W        = $clog2(SYMBOL_COUNT);
   localparam int FILL_W       = $clog2(SYMBOL_COUNT + 1);
   localparam int ROW_W        = $clog2(SQUARE_SIDE);
   localparam int QUEUE_DEPTH  = 2;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   localparam logic [CSR_ADDR_W-3:0] REG_ENCRYPT_MODE = '0;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef logic [SYM_W-1:0] sym_type;

   // One classified input beat as it waits in the queue.
   typedef struct packed {
      logic             is_text;
      logic             key_start;
      logic             key_last;
      logic             sym_valid;
      sym_type          sym;
      logic             is_space;
      logic             is_row_digit;
      logic [ROW_W-1:0] digit;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COLUMN,
      ST_FILL
   } back_state_type;

endpackage

@@ design/kpsc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts request beats and classifies the character.
// Depends on kpsc_pkg for the item type and character constants.
module kpsc_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kpsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             q_full,
   output logic                             q_push,
   output kpsc_pkg::item_type               q_item
);

   logic [7:0] ch;
   logic [7:0] upper;
   logic [7:0] offset;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign ch         = req_tdata[7:0];

   always_comb begin
      upper  = ch;
      offset = '0;
      if (ch >= kpsc_pkg::CHAR_LOWER_A && ch <= kpsc_pkg::CHAR_LOWER_Z) begin
         upper = ch - kpsc_pkg::CASE_OFFSET;
      end

      q_item.is_text   = req_tuser;
      q_item.key_start = req_tdata[8];
      q_item.key_last  = req_tlast;
      q_item.sym_valid = 1'b0;
      q_item.sym       = '0;

      if (upper >= kpsc_pkg::CHAR_UPPER_A && upper <= kpsc_pkg::CHAR_UPPER_Z) begin
         offset           = upper - kpsc_pkg::CHAR_UPPER_A;
         q_item.sym_valid = 1'b1;
         q_item.sym       = offset[kpsc_pkg::SYM_W-1:0];
      end else if (ch >= kpsc_pkg::CHAR_ZERO && ch <= kpsc_pkg::CHAR_NINE) begin
         offset           = (ch - kpsc_pkg::CHAR_ZERO) + 8'(kpsc_pkg::LETTER_COUNT);
         q_item.sym_valid = 1'b1;
         q_item.sym       = offset[kpsc_pkg::SYM_W-1:0];
      end

      q_item.is_space     = (ch == kpsc_pkg::CHAR_SPACE);
      q_item.is_row_digit = (ch >= kpsc_pkg::CHAR_ZERO) &&
                            (ch < kpsc_pkg::CHAR_ZERO + 8'(kpsc_pkg::SQUARE_SIDE));
      q_item.digit        = kpsc_pkg::ROW_W'(ch - kpsc_pkg::CHAR_ZERO);
   end

endmodule

@@ design/kpsc_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back ends.
// Depends on kpsc_pkg for the item type.
module kpsc_queue #(
   parameter int DEPTH = kpsc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kpsc_pkg::item_type push_item,
   input  logic               pop,
   output kpsc_pkg::item_type head,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kpsc_pkg::item_type slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/kpsc_back.sv @@
`timescale 1ns / 1ps
// Back end: holds the square, runs key updates, the alphabet fill and lookups,
// and drives the result register. Depends on kpsc_pkg.
module kpsc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  kpsc_pkg::item_type               head,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  logic                             encrypt_mode,
   input  logic                             row_clear,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kpsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int SYM_W  = kpsc_pkg::SYM_W;
   localparam int FILL_W = kpsc_pkg::FILL_W;
   localparam int ROW_W  = kpsc_pkg::ROW_W;
   localparam int COUNT  = kpsc_pkg::SYMBOL_COUNT;
   localparam int SIDE   = kpsc_pkg::SQUARE_SIDE;

   function automatic logic [7:0] char_of(input kpsc_pkg::sym_type s);
      logic [7:0] wide;
      wide = 8'(s);
      if (wide < 8'(kpsc_pkg::LETTER_COUNT)) begin
         return kpsc_pkg::CHAR_UPPER_A + wide;
      end
      return kpsc_pkg::CHAR_ZERO + (wide - 8'(kpsc_pkg::LETTER_COUNT));
   endfunction

   function automatic logic [ROW_W-1:0] row_of(input kpsc_pkg::sym_type p);
      logic [ROW_W-1:0] r;
      r = '0;
      for (int k = 1; k < SIDE; k++) begin
         if (p >= SYM_W'(k * SIDE)) begin
            r = ROW_W'(k);
         end
      end
      return r;
   endfunction

   kpsc_pkg::sym_type square_mem   [COUNT];
   kpsc_pkg::sym_type position_mem [COUNT];
   kpsc_pkg::sym_type rd_square_ff;
   kpsc_pkg::sym_type rd_position_ff;

   kpsc_pkg::back_state_type state_ff, state_in;
   logic [COUNT-1:0]  present_ff, present_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              keyed_ff, keyed_in;
   logic              pend_ff, pend_in;
   logic [ROW_W-1:0]  held_ff, held_in;
   kpsc_pkg::sym_type idx_ff, idx_in;
   kpsc_pkg::sym_type look_key_ff, look_key_in;
   logic              look_enc_ff, look_enc_in;
   logic [ROW_W-1:0]  col_ff, col_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;

   logic              wr_en;
   kpsc_pkg::sym_type wr_cell;
   kpsc_pkg::sym_type wr_sym;
   logic              out_free;
   kpsc_pkg::sym_type pair_cell;
   kpsc_pkg::sym_type pos;
   logic [ROW_W-1:0]  row;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;
   assign pair_cell  = (SYM_W'(held_ff) * SYM_W'(SIDE)) + SYM_W'(head.digit);
   assign pos        = keyed_ff ? rd_position_ff : look_key_ff;
   assign row        = row_of(pos);

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      fill_in      = fill_ff;
      keyed_in     = keyed_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      look_key_in  = look_key_ff;
      look_enc_in  = look_enc_ff;
      col_in       = col_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_cell      = fill_ff[SYM_W-1:0];
      wr_sym       = head.sym;

      unique case (state_ff)
         kpsc_pkg::ST_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (!head.is_text) begin
                  if (head.key_start) begin
                     present_in = '0;
                     fill_in    = '0;
                     pend_in    = 1'b0;
                     keyed_in   = 1'b1;
                  end
                  if (head.sym_valid && !present_in[head.sym] &&
                      fill_in < FILL_W'(COUNT)) begin
                     wr_en              = 1'b1;
                     wr_cell            = fill_in[SYM_W-1:0];
                     present_in[head.sym] = 1'b1;
                     fill_in            = fill_in + 1'b1;
                  end
                  if (head.key_last) begin
                     idx_in   = '0;
                     state_in = kpsc_pkg::ST_FILL;
                  end
               end else if (encrypt_mode) begin
                  if (head.is_space) begin
                     out_valid_in = 1'b1;
                     out_char_in  = kpsc_pkg::CHAR_SPACE;
                     out_last_in  = 1'b1;
                     out_err_in   = 1'b0;
                  end else if (head.sym_valid && present_ff[head.sym]) begin
                     look_key_in = head.sym;
                     look_enc_in = 1'b1;
                     state_in    = kpsc_pkg::ST_LOOKUP;
                  end
               end else if (!pend_ff) begin
                  if (head.is_space) begin
                     out_valid_in = 1'b1;
                     out_char_in  = kpsc_pkg::CHAR_SPACE;
                     out_last_in  = 1'b1;
                     out_err_in   = 1'b0;
                  end else if (head.is_row_digit) begin
                     held_in = head.digit;
                     pend_in = 1'b1;
                  end else begin
                     out_valid_in = 1'b1;
                     out_char_in  = '0;
                     out_last_in  = 1'b1;
                     out_err_in   = 1'b1;
                  end
               end else begin
                  pend_in = 1'b0;
                  if (head.is_row_digit && FILL_W'(pair_cell) < fill_ff) begin
                     look_key_in = pair_cell;
                     look_enc_in = 1'b0;
                     state_in    = kpsc_pkg::ST_LOOKUP;
                  end else begin
                     out_valid_in = 1'b1;
                     out_char_in  = '0;
                     out_last_in  = 1'b1;
                     out_err_in   = 1'b1;
                  end
               end
            end
         end
         kpsc_pkg::ST_LOOKUP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = 1'b0;
               if (look_enc_ff) begin
                  out_char_in = kpsc_pkg::CHAR_ZERO + 8'(row);
                  out_last_in = 1'b0;
                  col_in      = ROW_W'(pos - (SYM_W'(row) * SYM_W'(SIDE)));
                  state_in    = kpsc_pkg::ST_COLUMN;
               end else begin
                  out_char_in = char_of(keyed_ff ? rd_square_ff : look_key_ff);
                  out_last_in = 1'b1;
                  state_in    = kpsc_pkg::ST_IDLE;
               end
            end
         end
         kpsc_pkg::ST_COLUMN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = kpsc_pkg::CHAR_ZERO + 8'(col_ff);
               out_last_in  = 1'b1;
               out_err_in   = 1'b0;
               state_in     = kpsc_pkg::ST_IDLE;
            end
         end
         kpsc_pkg::ST_FILL: begin
            wr_sym = idx_ff;
            if (!present_ff[idx_ff] && fill_ff < FILL_W'(COUNT)) begin
               wr_en              = 1'b1;
               present_in[idx_ff] = 1'b1;
               fill_in            = fill_ff + 1'b1;
            end
            if (idx_ff == SYM_W'(COUNT - 1)) begin
               state_in = kpsc_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = kpsc_pkg::ST_IDLE;
         end
      endcase

      if (row_clear) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpsc_pkg::ST_IDLE;
         present_ff   <= '1;
         fill_ff      <= FILL_W'(COUNT);
         keyed_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         held_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         fill_ff      <= fill_in;
         keyed_ff     <= keyed_in;
         pend_ff      <= pend_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      look_key_ff <= look_key_in;
      look_enc_ff <= look_enc_in;
      col_ff      <= col_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   // Square memories: one write port each, read at the next lookup key.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         square_mem[wr_cell]  <= wr_sym;
         position_mem[wr_sym] <= wr_cell;
      end
      rd_square_ff   <= square_mem[look_key_in];
      rd_position_ff <= position_mem[look_key_in];
   end

endmodule

@@ design/keyed_polybius_square_cipher.sv @@
`timescale 1ns / 1ps
// Keyed 6x6 Polybius square cipher over A-Z and 0-9, top level.
// Request beats enter on req_*, result beats leave on rsp_*, and the mode
// register is written over the csr_* port. The front end classifies each
// request beat and parks it in a short queue; the back end owns the square.
// Key beats (req_tuser 0) build the square and give no result. A key beat with
// tlast set starts a fill pass that appends the missing symbols.
// Text beats (req_tuser 1) give zero, one or two result beats; rsp_tlast marks
// the final result beat of a text beat and rsp_tuser flags an error.
// A space or an error gives its result beat straight from ST_IDLE through the
// result register. A decrypted symbol or a row digit first passes ST_LOOKUP,
// since the square memories have a registered read port; the column digit
// then follows from ST_COLUMN once the result register is free. The back end
// takes no new beat from the queue until it is back in ST_IDLE, so a lookup,
// a digit pair or a fill pass holds the queue.
// After reset the square holds the unkeyed order and encryption is selected.
// A stalled receiver holds the result register; the queue then fills and
// req_tready drops until the results are taken.
module keyed_polybius_square_cipher #(
   parameter int QUEUE_DEPTH = kpsc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: char_code [7:0], key_start [8], zero fill [15:9]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kpsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: operation (0 key, 1 text)
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   // rsp_tdata: out_char [7:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kpsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: error
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [kpsc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [kpsc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [kpsc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic               encrypt_mode_ff, encrypt_mode_in;
   logic               mode_write;
   logic               reg_hit;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   kpsc_pkg::item_type q_item;
   kpsc_pkg::item_type q_head;

   // The register index is the word address; byte-lane bits are not decoded.
   assign reg_hit    = (csr_paddr[kpsc_pkg::CSR_ADDR_W-1:2] == kpsc_pkg::REG_ENCRYPT_MODE);
   assign csr_pready = 1'b1;
   assign mode_write = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign csr_prdata = reg_hit ? kpsc_pkg::CSR_DATA_W'(encrypt_mode_ff) : '0;

   always_comb begin
      encrypt_mode_in = encrypt_mode_ff;
      if (mode_write) begin
         encrypt_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encrypt_mode_ff <= 1'b1;
      end else begin
         encrypt_mode_ff <= encrypt_mode_in;
      end
   end

   kpsc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   kpsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // A mode write also drops any pending decrypt row.
   kpsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .encrypt_mode (encrypt_mode_ff),
      .row_clear    (mode_write),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
